// ===== sv/wsfu_pkg.sv =====
// Shared types and constants for the frame unmasker.
package wsfu_pkg;

	localparam logic [7:0] TEXT_FINAL = 8'd129;
	localparam logic [7:0] MASK_BIT   = 8'h80;
	localparam logic [7:0] LEN_CODE   = 8'h7F;
	localparam logic [6:0] LEN_CODE16 = 7'd126;
	localparam logic [6:0] LEN_CODE64 = 7'd127;
	localparam logic [3:0] EXT16_BYTES = 4'd2;
	localparam logic [3:0] EXT64_BYTES = 4'd8;
	localparam logic [3:0] KEY_BYTES   = 4'd4;

	typedef enum logic [2:0] {
		PH_FIRST   = 3'd0,
		PH_SECOND  = 3'd1,
		PH_EXTLEN  = 3'd2,
		PH_KEY     = 3'd3,
		PH_PAYLOAD = 3'd4,
		PH_PASS    = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		KIND_PASS   = 2'd0,
		KIND_MASKED = 2'd1,
		KIND_PLAIN  = 2'd2
	} kind_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_valid;
		logic       out_last;
		logic [1:0] frame_kind;
	} result_t;

endpackage

// ===== sv/wsfu_parser.sv =====
// Header parser, length tracking and payload unmask logic.
module wsfu_parser #(
	parameter int LENGTH_BITS = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [7:0]        in_byte,
	input  logic              end_of_message,
	output wsfu_pkg::result_t result
);

	wsfu_pkg::phase_t phase_q, phase_d;
	wsfu_pkg::kind_t  kind_q, kind_d;
	logic [3:0]             hdr_left_q, hdr_left_d;
	logic [LENGTH_BITS-1:0] remain_q, remain_d;
	logic [31:0]            key_q, key_d;
	logic [1:0]             key_idx_q, key_idx_d;
	logic [3:0]             hdr_dec;
	logic [6:0]             code;

	assign hdr_dec = hdr_left_q - 4'd1;
	assign code    = in_byte[6:0] & wsfu_pkg::LEN_CODE[6:0];

	always_comb begin
		phase_d    = phase_q;
		kind_d     = kind_q;
		hdr_left_d = hdr_left_q;
		remain_d   = remain_q;
		key_d      = key_q;
		key_idx_d  = key_idx_q;
		result     = '0;
		unique case (phase_q)
			wsfu_pkg::PH_FIRST: begin
				kind_d = wsfu_pkg::KIND_PASS;
				if (in_byte == wsfu_pkg::TEXT_FINAL) begin
					phase_d = wsfu_pkg::PH_SECOND;
				end else begin
					phase_d          = wsfu_pkg::PH_PASS;
					result.out_byte  = in_byte;
					result.out_valid = 1'b1;
				end
			end
			wsfu_pkg::PH_SECOND: begin
				kind_d = ((in_byte & wsfu_pkg::MASK_BIT) != 8'd0) ?
					wsfu_pkg::KIND_MASKED : wsfu_pkg::KIND_PLAIN;
				remain_d = '0;
				if (code == wsfu_pkg::LEN_CODE16) begin
					phase_d    = wsfu_pkg::PH_EXTLEN;
					hdr_left_d = wsfu_pkg::EXT16_BYTES;
				end else if (code == wsfu_pkg::LEN_CODE64) begin
					phase_d    = wsfu_pkg::PH_EXTLEN;
					hdr_left_d = wsfu_pkg::EXT64_BYTES;
				end else begin
					remain_d = LENGTH_BITS'(code);
					if (kind_d == wsfu_pkg::KIND_MASKED) begin
						phase_d    = wsfu_pkg::PH_KEY;
						hdr_left_d = wsfu_pkg::KEY_BYTES;
					end else begin
						phase_d    = wsfu_pkg::PH_PAYLOAD;
						hdr_left_d = 4'd0;
					end
				end
			end
			wsfu_pkg::PH_EXTLEN: begin
				if (remain_q[LENGTH_BITS-1 -: 8] != 8'd0) begin
					remain_d = {LENGTH_BITS{1'b1}};
				end else begin
					remain_d = {remain_q[LENGTH_BITS-9:0], in_byte};
				end
				hdr_left_d = hdr_dec;
				if (hdr_dec == 4'd0) begin
					if (kind_q == wsfu_pkg::KIND_MASKED) begin
						phase_d    = wsfu_pkg::PH_KEY;
						hdr_left_d = wsfu_pkg::KEY_BYTES;
					end else begin
						phase_d    = wsfu_pkg::PH_PAYLOAD;
						hdr_left_d = 4'd0;
					end
				end
			end
			wsfu_pkg::PH_KEY: begin
				key_d      = {key_q[23:0], in_byte};
				hdr_left_d = hdr_dec;
				if (hdr_dec == 4'd0) begin
					phase_d   = wsfu_pkg::PH_PAYLOAD;
					key_idx_d = 2'd0;
				end
			end
			wsfu_pkg::PH_PAYLOAD: begin
				if (kind_q == wsfu_pkg::KIND_MASKED) begin
					if (remain_q != '0) begin
						result.out_byte  = in_byte ^ key_q[{~key_idx_q, 3'b000} +: 8];
						result.out_valid = 1'b1;
						key_idx_d        = key_idx_q + 2'd1;
						remain_d         = remain_q - LENGTH_BITS'(1);
					end
				end else begin
					result.out_byte  = in_byte;
					result.out_valid = 1'b1;
				end
			end
			default: begin
				result.out_byte  = in_byte;
				result.out_valid = 1'b1;
			end
		endcase
		result.out_last   = end_of_message;
		result.frame_kind = kind_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= wsfu_pkg::PH_FIRST;
			kind_q     <= wsfu_pkg::KIND_PASS;
			hdr_left_q <= '0;
			remain_q   <= '0;
			key_q      <= '0;
			key_idx_q  <= '0;
		end else if (accept) begin
			if (end_of_message) begin
				phase_q    <= wsfu_pkg::PH_FIRST;
				kind_q     <= wsfu_pkg::KIND_PASS;
				hdr_left_q <= '0;
				remain_q   <= '0;
				key_q      <= '0;
				key_idx_q  <= '0;
			end else begin
				phase_q    <= phase_d;
				kind_q     <= kind_d;
				hdr_left_q <= hdr_left_d;
				remain_q   <= remain_d;
				key_q      <= key_d;
				key_idx_q  <= key_idx_d;
			end
		end
	end

	a_clear_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		accept && end_of_message |=> phase_q == wsfu_pkg::PH_FIRST)
		else $error("state not cleared after last word");

	a_key_masked: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == wsfu_pkg::PH_KEY |-> kind_q == wsfu_pkg::KIND_MASKED)
		else $error("key phase in unmasked frame");

	a_hdr_count: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == wsfu_pkg::PH_EXTLEN || phase_q == wsfu_pkg::PH_KEY)
		|-> hdr_left_q != 4'd0)
		else $error("header count empty inside header");

endmodule

// ===== sv/wsfu_out_reg.sv =====
// Result register that decouples the receiver from the parser.
module wsfu_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load_valid,
	output logic              load_ready,
	input  wsfu_pkg::result_t load_data,
	output logic              res_valid,
	input  logic              res_ready,
	output wsfu_pkg::result_t res_data
);

	logic              valid_s1;
	wsfu_pkg::result_t data_s1;

	assign load_ready = !valid_s1 || res_ready;
	assign res_valid  = valid_s1;
	assign res_data   = data_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_ready) begin
			valid_s1 <= load_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_ready && load_valid) begin
			data_s1 <= load_data;
		end
	end

endmodule

// ===== sv/websocket_frame_unmasker.sv =====
// Top level of the frame unmasker: parser plus result register.
//
// Input channel: in_valid/in_ready carry one received word (in_byte) and
// end_of_message, which marks the final word of a message.
// Result channel: res_valid/res_ready carry exactly one result per input word:
// out_byte, out_valid (out_byte holds payload), out_last and frame_kind.
// Each result is registered: it is shown on res_valid the cycle after its word is taken.
// Throughput: one word per cycle unless a result waits with res_ready low; header parse,
// length count and the key XOR are all combinational ahead of the result register.
// The 64-bit style length decrement is the longest path.
// Stall: while a result waits and res_ready is low, in_ready drops; when
// res_ready is high a new word is taken in the same cycle the old result goes.
// Reset: arst_n clears the parser to expect the first header word and empties
// the result register. State also clears after each word marked end_of_message.
module websocket_frame_unmasker #(
	parameter int LENGTH_BITS = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       end_of_message,
	output logic       res_valid,
	input  logic       res_ready,
	output logic [7:0] out_byte,
	output logic       out_valid,
	output logic       out_last,
	output logic [1:0] frame_kind
);

	wsfu_pkg::result_t parse_res;
	wsfu_pkg::result_t res_data;
	logic              accept;

	assign accept = in_valid && in_ready;

	wsfu_parser #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_parser (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.in_byte        (in_byte),
		.end_of_message (end_of_message),
		.result         (parse_res)
	);

	wsfu_out_reg u_out_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (in_valid),
		.load_ready (in_ready),
		.load_data  (parse_res),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res_data   (res_data)
	);

	assign out_byte   = res_data.out_byte;
	assign out_valid  = res_data.out_valid;
	assign out_last   = res_data.out_last;
	assign frame_kind = res_data.frame_kind;

	a_dropped_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !out_valid |-> out_byte == 8'd0)
		else $error("dropped word carries data");

	a_passthrough_kind: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !end_of_message && in_byte != wsfu_pkg::TEXT_FINAL
		&& $past(accept && end_of_message) |=> frame_kind == wsfu_pkg::KIND_PASS)
		else $error("non-text frame reported as text");

	a_take_on_drain: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready |-> in_ready)
		else $error("input blocked while result drains");

endmodule
